// ----- rtl/core/fccr_pkg.sv -----
// Shared types and constants of the FAT16 cluster chain reader.
package fccr_pkg;

   // Command codes of an input item
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Result status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_START = 3'd1;
   localparam logic [2:0] STATUS_SHORT     = 3'd2;
   localparam logic [2:0] STATUS_TRUNC     = 3'd3;
   localparam logic [2:0] STATUS_OUT_TABLE = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_PARTITION_LBA    = 3'd0;
   localparam logic [2:0] CSR_SECTOR_BYTES     = 3'd1;
   localparam logic [2:0] CSR_CLUSTER_SECTORS  = 3'd2;
   localparam logic [2:0] CSR_RESERVED_SECTORS = 3'd3;
   localparam logic [2:0] CSR_TABLE_COPIES     = 3'd4;
   localparam logic [2:0] CSR_TABLE_SECTORS    = 3'd5;
   localparam logic [2:0] CSR_ROOT_ENTRIES     = 3'd6;

   // FAT16 constants
   localparam logic [15:0] END_MARK          = 16'hFFF7;
   localparam logic [15:0] FIRST_CLUSTER     = 16'd2;
   localparam logic [19:0] MAX_CLUSTER_BYTES = 20'd524288;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEOM1,
      ST_GEOM2,
      ST_GEOM3,
      ST_LOOKUP,
      ST_SEGMENT
   } fccr_state_type;

endpackage

// ----- rtl/core/fat16_cluster_chain_reader.sv -----
// FAT16 cluster chain reader: allocation table store and chain walker.
//
// The block holds a FAT16 allocation table in a RAM and walks cluster chains
// on request. An item with cmd 0 writes one table entry (indexes at or above
// TABLE_ENTRIES are dropped) and gives no result. An item with
// cmd 1 gives a start cluster and a file length; the block emits one copy
// segment per cluster (disk byte offset, file offset, length, last, status),
// the final one clamped to the bytes that remain. A start below 2, a cluster
// outside the table, an early end of chain and a chain longer than
// MAX_SEGMENTS each end the read with a flagged status. A read works out the
// volume geometry (cluster size and the byte offset of the data area, through
// registered multipliers) in ST_GEOM1 to ST_GEOM3, then takes each cluster in
// ST_LOOKUP, which issues the table read and forms (cluster-2)*cluster size,
// and ST_SEGMENT, where the RAM's registered read data picks the next cluster
// and the segment is formed; result channel stalls hold the walk. One item is
// in work at a time. The table is only written while the walker is idle, so
// reads and writes of one entry never overlap. Table contents are undefined
// after reset until written; there is no clearing pass. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module fat16_cluster_chain_reader
   import fccr_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_SEGMENTS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // request items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [11:0] req_entry_index,
   input  logic [15:0] req_entry_value,
   input  logic [15:0] req_start_cluster,
   input  logic [31:0] req_file_bytes,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [41:0] rsp_disk_offset,
   output logic [31:0] rsp_file_offset,
   output logic [19:0] rsp_seg_length,
   output logic        rsp_last,
   output logic [2:0]  rsp_status
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // configuration registers
   logic [31:0] partition_lba_ff;
   logic [12:0] sector_bytes_ff;
   logic [7:0]  cluster_sectors_ff;
   logic [15:0] reserved_sectors_ff;
   logic [2:0]  table_copies_ff;
   logic [15:0] table_sectors_ff;
   logic [15:0] root_entries_ff;

   // control
   fccr_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    cur_ff, cur_in;
   logic [31:0]    bytes_done_ff, bytes_done_in;
   logic [6:0]     seg_count_ff, seg_count_in;

   // read parameters and geometry
   logic [15:0] start_ff, start_in;
   logic [31:0] size_ff, size_in;
   logic [28:0] prod_a_ff, prod_a_in;     // reserved * sector bytes
   logic [18:0] prod_b_ff, prod_b_in;     // copies * table sectors
   logic [31:0] prod_c_ff, prod_c_in;     // all table bytes
   logic [20:0] cs_raw_ff, cs_raw_in;
   logic [19:0] cs_ff, cs_in;             // saturated cluster bytes
   logic [41:0] base_ff, base_in;         // byte offset of cluster 2
   logic [35:0] off_prod_ff, off_prod_in;
   logic [31:0] rem_ff, rem_in;

   // result payload
   logic [41:0] disk_ff, disk_in;
   logic [31:0] foff_ff, foff_in;
   logic [19:0] len_ff, len_in;
   logic        last_ff, last_in;
   logic [2:0]  status_ff, status_in;

   // table RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_wr_addr;
   logic             ram_re;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [15:0]      ram_rd_data;

   logic        req_take;
   logic        out_free;
   logic        out_load;
   logic [16:0] wr_ext;
   logic [16:0] cur_ext;
   logic        eoc;
   logic        fin;
   logic        trunc;
   logic [6:0]  cnt_next;
   logic [19:0] seg_len;

   fccr_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_entry_value),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         partition_lba_ff    <= '0;
         sector_bytes_ff     <= 13'd512;
         cluster_sectors_ff  <= 8'd1;
         reserved_sectors_ff <= 16'd1;
         table_copies_ff     <= 3'd2;
         table_sectors_ff    <= '0;
         root_entries_ff     <= 16'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PARTITION_LBA:    partition_lba_ff    <= csr_wdata;
            CSR_SECTOR_BYTES:     sector_bytes_ff     <= csr_wdata[12:0];
            CSR_CLUSTER_SECTORS:  cluster_sectors_ff  <= csr_wdata[7:0];
            CSR_RESERVED_SECTORS: reserved_sectors_ff <= csr_wdata[15:0];
            CSR_TABLE_COPIES:     table_copies_ff     <= csr_wdata[2:0];
            CSR_TABLE_SECTORS:    table_sectors_ff    <= csr_wdata[15:0];
            CSR_ROOT_ENTRIES:     root_entries_ff     <= csr_wdata[15:0];
            default: ;  // unknown index: ignored
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_ext  = 17'(req_entry_index);
   assign cur_ext = 17'(cur_ff);
   assign ram_wr_addr = wr_ext[IDX_W-1:0];
   assign ram_rd_addr = cur_ext[IDX_W-1:0];

   // segment decisions, valid in ST_SEGMENT
   assign eoc      = (ram_rd_data >= END_MARK) || (ram_rd_data < FIRST_CLUSTER);
   assign fin      = (rem_ff <= 32'(cs_ff));
   assign cnt_next = seg_count_ff + 7'd1;
   assign trunc    = (cnt_next >= 7'(MAX_SEGMENTS));
   assign seg_len  = (rem_ff < 32'(cs_ff)) ? rem_ff[19:0] : cs_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cur_in        = cur_ff;
      bytes_done_in = bytes_done_ff;
      seg_count_in  = seg_count_ff;
      start_in      = start_ff;
      size_in       = size_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      prod_c_in     = prod_c_ff;
      cs_raw_in     = cs_raw_ff;
      cs_in         = cs_ff;
      base_in       = base_ff;
      off_prod_in   = off_prod_ff;
      rem_in        = rem_ff;
      disk_in       = disk_ff;
      foff_in       = foff_ff;
      len_in        = len_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      out_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == CMD_WRITE) begin
                  ram_we = (wr_ext < 17'(TABLE_ENTRIES));
               end else begin
                  start_in      = req_start_cluster;
                  size_in       = req_file_bytes;
                  cur_in        = req_start_cluster;
                  bytes_done_in = '0;
                  seg_count_in  = '0;
                  state_in      = ST_GEOM1;
               end
            end
         end
         ST_GEOM1: begin
            prod_a_in = 29'(reserved_sectors_ff) * 29'(sector_bytes_ff);
            prod_b_in = 19'(table_copies_ff) * 19'(table_sectors_ff);
            cs_raw_in = 21'(sector_bytes_ff) * 21'(cluster_sectors_ff);
            state_in  = ST_GEOM2;
         end
         ST_GEOM2: begin
            prod_c_in = 32'(prod_b_ff) * 32'(sector_bytes_ff);
            cs_in     = (cs_raw_ff > 21'(MAX_CLUSTER_BYTES)) ? MAX_CLUSTER_BYTES
                                                             : cs_raw_ff[19:0];
            base_in   = {1'b0, partition_lba_ff, 9'd0} + 42'(prod_a_ff)
                      + 42'({root_entries_ff, 5'd0});
            state_in  = ST_GEOM3;
         end
         ST_GEOM3: begin
            base_in = base_ff + 42'(prod_c_ff);
            if ((start_ff < FIRST_CLUSTER) || (size_ff == '0)) begin
               // bad start or empty file: one empty final result
               if (out_free) begin
                  out_load  = 1'b1;
                  disk_in   = '0;
                  foff_in   = '0;
                  len_in    = '0;
                  last_in   = 1'b1;
                  status_in = (start_ff < FIRST_CLUSTER) ? STATUS_BAD_START
                                                         : STATUS_OK;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cur_ext >= 17'(TABLE_ENTRIES)) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  disk_in   = '0;
                  foff_in   = '0;
                  len_in    = '0;
                  last_in   = 1'b1;
                  status_in = STATUS_OUT_TABLE;
                  state_in  = ST_IDLE;
               end
            end else begin
               ram_re      = 1'b1;
               rem_in      = size_ff - bytes_done_ff;
               off_prod_in = 36'(cur_ff - FIRST_CLUSTER) * 36'(cs_ff);
               state_in    = ST_SEGMENT;
            end
         end
         ST_SEGMENT: begin
            // read data holds while waiting for the output register
            if (out_free) begin
               out_load      = 1'b1;
               disk_in       = base_ff + 42'(off_prod_ff);
               foff_in       = bytes_done_ff;
               len_in        = seg_len;
               bytes_done_in = bytes_done_ff + 32'(seg_len);
               seg_count_in  = cnt_next;
               cur_in        = ram_rd_data;
               priority if (fin) begin
                  last_in   = 1'b1;
                  status_in = STATUS_OK;
               end else if (eoc) begin
                  last_in   = 1'b1;
                  status_in = STATUS_SHORT;
               end else if (trunc) begin
                  last_in   = 1'b1;
                  status_in = STATUS_TRUNC;
               end else begin
                  last_in   = 1'b0;
                  status_in = STATUS_OK;
               end
               state_in = last_in ? ST_IDLE : ST_LOOKUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_ff        <= '0;
         bytes_done_ff <= '0;
         seg_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_ff        <= cur_in;
         bytes_done_ff <= bytes_done_in;
         seg_count_ff  <= seg_count_in;
      end
   end

   // datapath and payload, no reset
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      size_ff     <= size_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      prod_c_ff   <= prod_c_in;
      cs_raw_ff   <= cs_raw_in;
      cs_ff       <= cs_in;
      base_ff     <= base_in;
      off_prod_ff <= off_prod_in;
      rem_ff      <= rem_in;
      disk_ff     <= disk_in;
      foff_ff     <= foff_in;
      len_ff      <= len_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_disk_offset = disk_ff;
   assign rsp_file_offset = foff_ff;
   assign rsp_seg_length  = len_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;

   // table is never written while a walk is in progress
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("table write outside idle");

   // a final result returns the walker to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_in) |=> (state_ff == ST_IDLE))
      else $error("walker busy after final result");

   // segment count stays within the limit
   a_seg_limit: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= 7'(MAX_SEGMENTS))
      else $error("segment count beyond limit");

   // a read item starts the geometry setup
   a_read_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_cmd == CMD_READ)) |=> (state_ff == ST_GEOM1))
      else $error("read item did not start a walk");

endmodule

// ----- rtl/core/fccr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fccr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/fat16_cluster_chain_reader_test.sv -----
// Self-checking testbench for the FAT16 cluster chain reader: table writes, chain walks, geometry.
`timescale 1ns / 100ps

module fat16_cluster_chain_reader_test;
   import fccr_pkg::*;

   localparam int TABLE_ENTRIES   = 4096;
   localparam int MAX_SEGMENTS    = 64;
   localparam int LBA_BYTES       = 512;
   localparam int DIR_ENTRY_BYTES = 32;
   localparam int QUIET_CYCLES    = 8;     // a write item does not leave the block busy
   localparam int LONG_HOLD       = 300;   // receiver hold-off, long enough to back up the input

   // one copy segment as the block reports it
   typedef struct packed {
      logic [41:0] disk_offset;
      logic [31:0] file_offset;
      logic [19:0] seg_length;
      logic        last;
      logic [2:0]  status;
   } segment_type;

   // volume geometry, one field per configuration register
   typedef struct packed {
      logic [31:0] partition_lba;
      logic [12:0] sector_bytes;
      logic [7:0]  cluster_sectors;
      logic [15:0] reserved_sectors;
      logic [2:0]  table_copies;
      logic [15:0] table_sectors;
      logic [15:0] root_entries;
   } geometry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_PARTITION_LBA;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_WRITE;
   logic [11:0] req_entry_index = '0;
   logic [15:0] req_entry_value = '0;
   logic [15:0] req_start_cluster = '0;
   logic [31:0] req_file_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [41:0] rsp_disk_offset;
   logic [31:0] rsp_file_offset;
   logic [19:0] rsp_seg_length;
   logic        rsp_last;
   logic [2:0]  rsp_status;

   // shadow of the block's state, kept in step with accepted items
   logic [15:0]  fat_copy [TABLE_ENTRIES];
   bit           fat_written [TABLE_ENTRIES];
   geometry_type geo = '{partition_lba: 32'd0, sector_bytes: 13'd512, cluster_sectors: 8'd1,
                         reserved_sectors: 16'd1, table_copies: 3'd2, table_sectors: 16'd0,
                         root_entries: 16'd512};

   segment_type segments_due [$];
   int unsigned items_accepted = 0;
   int          failures = 0;

   // idling controls, switched per test phase
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int          rsp_wait = 0;
   int          hold_request = 0;
   int          hold_left = 0;

   fat16_cluster_chain_reader #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_SEGMENTS  (MAX_SEGMENTS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_start_cluster (req_start_cluster),
      .req_file_bytes    (req_file_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_disk_offset   (rsp_disk_offset),
      .rsp_file_offset   (rsp_file_offset),
      .rsp_seg_length    (rsp_seg_length),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // bytes per cluster, saturated so that huge geometries stay within a segment
   function automatic logic [31:0] cluster_bytes();
      logic [31:0] size;
      size = 32'(geo.sector_bytes) * 32'(geo.cluster_sectors);
      return (size > 32'(MAX_CLUSTER_BYTES)) ? 32'(MAX_CLUSTER_BYTES) : size;
   endfunction

   // data area start plus the cluster's stride, wrapped to the 42-bit offset
   function automatic logic [41:0] disk_offset_of(logic [15:0] cluster);
      logic [63:0] sum;
      sum = 64'(geo.partition_lba) * 64'(LBA_BYTES)
          + 64'(geo.reserved_sectors) * 64'(geo.sector_bytes)
          + 64'(geo.table_copies) * 64'(geo.table_sectors) * 64'(geo.sector_bytes)
          + 64'(geo.root_entries) * 64'(DIR_ENTRY_BYTES)
          + (64'(cluster) - 64'd2) * 64'(cluster_bytes());
      return sum[41:0];
   endfunction

   // Walks the shadow table as the block would for one read. Returns -1 with the
   // segments filled in, or the first visited entry that has never been written.
   function automatic int walk_chain(input logic [15:0] start, input logic [31:0] file_bytes,
                                     output segment_type segs[$]);
      logic [31:0] csize, done, remaining, length;
      logic [15:0] cur, next_cluster;
      int unsigned count;
      segment_type seg;
      segs.delete();
      seg = '0;
      seg.last = 1'b1;
      if (start < FIRST_CLUSTER || file_bytes == 0) begin
         seg.status = (start < FIRST_CLUSTER) ? STATUS_BAD_START : STATUS_OK;
         segs.push_back(seg);
         return -1;
      end
      csize = cluster_bytes();
      cur = start;
      done = '0;
      count = 0;
      forever begin
         seg = '0;
         seg.last = 1'b1;
         if (cur >= TABLE_ENTRIES) begin
            seg.status = STATUS_OUT_TABLE;
            segs.push_back(seg);
            return -1;
         end
         if (!fat_written[cur]) return int'(cur);
         remaining = file_bytes - done;
         length = (remaining < csize) ? remaining : csize;
         next_cluster = fat_copy[cur];
         count++;
         // the final segment wins over an early end and over the segment limit
         if (remaining <= csize) seg.status = STATUS_OK;
         else if (next_cluster >= END_MARK || next_cluster < FIRST_CLUSTER)
            seg.status = STATUS_SHORT;
         else if (count >= MAX_SEGMENTS) seg.status = STATUS_TRUNC;
         else seg.last = 1'b0;
         seg.disk_offset = disk_offset_of(cur);
         seg.file_offset = done;
         seg.seg_length = length[19:0];
         segs.push_back(seg);
         if (seg.last) return -1;
         done += length;
         cur = next_cluster;
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Offers one item and waits for it to be taken; the shadow state follows on
   // acceptance. Leaves valid high at the falling edge after the handshake.
   task automatic send_item(logic cmd, logic [11:0] index, logic [15:0] value,
                            logic [15:0] start, logic [31:0] file_bytes);
      int unsigned gap;
      segment_type segs[$];
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_entry_index   <= index;
      req_entry_value   <= value;
      req_start_cluster <= start;
      req_file_bytes    <= file_bytes;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_WRITE) begin
         if (index < TABLE_ENTRIES) begin
            fat_copy[index] = value;
            fat_written[index] = 1'b1;
         end
      end else begin
         void'(walk_chain(start, file_bytes, segs));
         foreach (segs[i]) segments_due.push_back(segs[i]);
      end
      items_accepted++;
      @(negedge clock);
   endtask

   task automatic write_entry(logic [11:0] index, logic [15:0] value);
      send_item(CMD_WRITE, index, value, 16'($urandom), $urandom);
   endtask

   // Any entry the walk would touch but which holds nothing yet gets a random
   // link first, so the block never reads an unwritten entry.
   task automatic fetch_file(logic [15:0] start, logic [31:0] file_bytes);
      segment_type segs[$];
      int          hole;
      hole = walk_chain(start, file_bytes, segs);
      while (hole >= 0) begin
         write_entry(12'(hole), random_link());
         hole = walk_chain(start, file_bytes, segs);
      end
      send_item(CMD_READ, 12'($urandom), 16'($urandom), start, file_bytes);
   endtask

   function automatic logic [15:0] random_chain_end();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(32'hFFF7, 32'hFFFF));        // end marks
         1: return 16'($urandom_range(0, 1));                      // free or reserved
         2: return 16'($urandom_range(TABLE_ENTRIES, 32'hFFF6));   // beyond the table
         default: return END_MARK;
      endcase
   endfunction

   function automatic logic [15:0] random_link();
      if ($urandom_range(0, 9) < 3) return random_chain_end();
      return 16'($urandom_range(FIRST_CLUSTER, TABLE_ENTRIES - 1));
   endfunction

   // a length around the given cluster count: exact, clamped, zero or anything at all
   function automatic logic [31:0] random_size(int unsigned clusters);
      logic [31:0] csize;
      csize = cluster_bytes();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'd0;
         2, 3: return csize * clusters;
         default: return csize * (clusters - 1) + $urandom_range(1, csize);
      endcase
   endfunction

   // lays down a linked chain of the given length with a random ending, then reads it
   task automatic read_chain(int unsigned clusters);
      logic [15:0] start, cur, next_cluster;
      start = 16'($urandom_range(FIRST_CLUSTER, TABLE_ENTRIES - 1));
      cur = start;
      for (int i = 1; i < clusters; i++) begin
         next_cluster = 16'($urandom_range(FIRST_CLUSTER, TABLE_ENTRIES - 1));
         write_entry(cur[11:0], next_cluster);
         cur = next_cluster;
      end
      write_entry(cur[11:0], random_chain_end());
      fetch_file(start, random_size($urandom_range(1, clusters + 1)));
   endtask

   // sender pauses until every segment is back, then lets the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (segments_due.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // every register written, with enable held high across the burst
   task automatic set_geometry(geometry_type g);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_PARTITION_LBA;    csr_wdata <= g.partition_lba;            @(negedge clock);
      csr_index <= CSR_SECTOR_BYTES;     csr_wdata <= 32'(g.sector_bytes);        @(negedge clock);
      csr_index <= CSR_CLUSTER_SECTORS;  csr_wdata <= 32'(g.cluster_sectors);     @(negedge clock);
      csr_index <= CSR_RESERVED_SECTORS; csr_wdata <= 32'(g.reserved_sectors);    @(negedge clock);
      csr_index <= CSR_TABLE_COPIES;     csr_wdata <= 32'(g.table_copies);        @(negedge clock);
      csr_index <= CSR_TABLE_SECTORS;    csr_wdata <= 32'(g.table_sectors);       @(negedge clock);
      csr_index <= CSR_ROOT_ENTRIES;     csr_wdata <= 32'(g.root_entries);        @(negedge clock);
      csr_we <= 1'b0;
      geo = g;
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (segments_due.size() == 0) begin
            $display("%0t: segment expected none, got disk_offset %0h file_offset %0h",
                     $time, rsp_disk_offset, rsp_file_offset);
            failures++;
         end else begin
            want = segments_due.pop_front();
            compare_field("disk_offset", 64'(want.disk_offset), 64'(rsp_disk_offset));
            compare_field("file_offset", 64'(want.file_offset), 64'(rsp_file_offset));
            compare_field("seg_length", 64'(want.seg_length), 64'(rsp_seg_length));
            compare_field("last", 64'(want.last), 64'(rsp_last));
            compare_field("status", 64'(want.status), 64'(rsp_status));
         end
         rsp_wait = receiver_idles ? $urandom_range(0, 8) : 0;
      end
   end

   // Receiver: stalls for the drawn count after each segment, and for a long
   // stretch whenever a test asks for one.
   initial forever begin
      @(negedge clock);
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- tests

   // default geometry (512-byte clusters); field extremes and every way a read ends
   task automatic test_table_and_walk();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      write_entry(12'd0, 16'hFFFF);
      write_entry(12'hFFF, 16'h0000);
      fetch_file(16'd0, 32'd100);               // start below 2
      fetch_file(16'd1, 32'hFFFF_FFFF);
      fetch_file(16'd5, 32'd0);                 // empty file, table untouched
      fetch_file(16'hFFFF, 32'hFFFF_FFFF);      // start outside the table
      fetch_file(16'd4096, 32'd1);
      fetch_file(16'hFFF, 32'd1000);            // free entry ends the chain early
      write_entry(12'd10, 16'd11);
      write_entry(12'd11, END_MARK);
      fetch_file(16'd10, 32'd1024);             // exactly two clusters
      fetch_file(16'd10, 32'd1500);             // end mark before the data runs out
      fetch_file(16'd10, 32'd300);              // single clamped segment
      write_entry(12'd20, 16'd5000);
      fetch_file(16'd20, 32'd2000);             // link leaves the table mid-walk
      write_entry(12'd30, 16'd30);
      fetch_file(16'd30, 32'hFFFF_FFFF);        // looped chain hits the segment limit
      fetch_file(16'd30, 32'd32768);            // 64 clusters exactly: final, not truncated
      write_entry(12'd40, 16'd1);
      fetch_file(16'd40, 32'd513);              // reserved value ends the chain
   endtask

   task automatic exercise_geometry(geometry_type g);
      logic [15:0] loop_cluster;
      set_geometry(g);
      read_chain(3);
      read_chain(2);
      loop_cluster = 16'($urandom_range(FIRST_CLUSTER, TABLE_ENTRIES - 1));
      write_entry(loop_cluster[11:0], loop_cluster);
      fetch_file(loop_cluster, 32'hFFFF_FFFF);
      fetch_file(random_link(), random_size(2));
   endtask

   // register extremes, a zero cluster size and an oversize cluster that saturates
   task automatic test_volume_geometry();
      exercise_geometry('{32'hFFFF_FFFF, 13'd4096, 8'd128, 16'hFFFF, 3'd4, 16'hFFFF, 16'hFFFF});
      exercise_geometry('{32'd0, 13'd128, 8'd1, 16'd0, 3'd1, 16'd0, 16'd0});
      exercise_geometry('{$urandom, 13'd512, 8'd0, 16'd1, 3'd2, 16'd32, 16'd512});
      // all ones: saturated cluster size
      exercise_geometry('{32'hFFFF_FFFF, 13'h1FFF, 8'hFF, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF});
   endtask

   // Mostly well-formed chains with random content, plus stray table writes and
   // reads from random starts. One phase runs with no idling on either side.
   task automatic test_random_traffic();
      geometry_type g;
      int unsigned  stop_at;
      for (int phase = 0; phase < 5; phase++) begin
         g.partition_lba    = $urandom;
         g.sector_bytes     = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(128, 4096))
                                                          : 13'(128 << $urandom_range(0, 5));
         g.cluster_sectors  = 8'($urandom_range(1, 128));
         g.reserved_sectors = 16'($urandom);
         g.table_copies     = 3'($urandom_range(1, 4));
         g.table_sectors    = 16'($urandom);
         g.root_entries     = 16'($urandom);
         set_geometry(g);
         sender_idles = (phase != 2);
         receiver_idles = (phase != 2);
         stop_at = items_accepted + 85;
         while (items_accepted < stop_at) begin
            case ($urandom_range(0, 9))
               0, 1: write_entry(12'($urandom), random_link());
               2, 3: fetch_file(random_link(), random_size(3));
               default: read_chain(($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                                 : $urandom_range(1, 8));
            endcase
         end
      end
   endtask

   // long receiver hold-off backs the block up; then the sender waits for a full drain
   task automatic test_result_backpressure();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      hold_request = LONG_HOLD;
      repeat (6) read_chain(4);
      settle();
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      repeat (4) read_chain($urandom_range(1, 5));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_table_and_walk();
      test_volume_geometry();
      test_random_traffic();
      test_result_backpressure();
      settle();
      repeat (20) @(negedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
